// ===== rtl/core/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// types and codes shared by the task table scheduler
// ----------------------------------------------------------------------------
package prr_pkg;

   localparam logic [2:0] OP_CREATE  = 3'd0;
   localparam logic [2:0] OP_START   = 3'd1;
   localparam logic [2:0] OP_TICK    = 3'd2;
   localparam logic [2:0] OP_YIELD   = 3'd3;
   localparam logic [2:0] OP_EXIT    = 3'd4;
   localparam logic [2:0] OP_REAP    = 3'd5;
   localparam logic [2:0] OP_INSPECT = 3'd6;

   localparam logic [2:0] ST_UNUSED  = 3'd0;
   localparam logic [2:0] ST_READY   = 3'd1;
   localparam logic [2:0] ST_RUNNING = 3'd2;
   localparam logic [2:0] ST_ZOMBIE  = 3'd4;

   localparam logic [2:0] RS_OK        = 3'd0;
   localparam logic [2:0] RS_NO_SLOT   = 3'd1;
   localparam logic [2:0] RS_NOT_FOUND = 3'd2;
   localparam logic [2:0] RS_NO_READY  = 3'd3;
   localparam logic [2:0] RS_HALTED    = 3'd4;

   typedef struct packed {
      logic [2:0]         operation;
      logic [31:0]        target_pid;
      logic [31:0]        parent_pid;
      logic               entry_ok;
      logic signed [31:0] exit_code;
      logic [3:0]         slot_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        assigned_pid;
      logic               switched;
      logic [3:0]         from_slot;
      logic [3:0]         to_slot;
      logic [31:0]        current_pid;
      logic [31:0]        current_parent;
      logic [31:0]        entry_pid;
      logic [2:0]         entry_state;
      logic [31:0]        entry_ticks;
      logic signed [31:0] entry_exit_status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture request, start scan
      logic step;     // examine one slot
      logic commit;   // apply the command and build the response
   } prr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;
   } prr_stat_type;

endpackage

// ===== rtl/core/prr_ctrl.sv =====
// ----------------------------------------------------------------------------
// prr_ctrl
// command sequencer: load, slot scan, commit, response hold
// ----------------------------------------------------------------------------
module prr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output prr_pkg::prr_cmd_type cmd,
   input  prr_pkg::prr_stat_type stat
);
   import prr_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // a new command enters once the previous response beat leaves
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (stat.scan_last) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!rsp_valid_ff) begin
               cmd.commit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/prr_dpath.sv =====
// ----------------------------------------------------------------------------
// prr_dpath
// slot table, slot-serial search and command execution
// ----------------------------------------------------------------------------
module prr_dpath #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prr_pkg::req_type      req_data,
   output prr_pkg::rsp_type      rsp_data,
   input  prr_pkg::prr_cmd_type  cmd,
   output prr_pkg::prr_stat_type stat
);
   import prr_pkg::*;

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

   logic [2:0]  st_ff [TABLE_SLOTS];
   logic [31:0] pid_ff [TABLE_SLOTS];
   logic [31:0] par_ff [TABLE_SLOTS];
   logic [31:0] tick_ff [TABLE_SLOTS];
   logic [31:0] exit_ff [TABLE_SLOTS];

   req_type     rq_ff;
   rsp_type     rsp_ff;
   logic        cur_v_ff;
   logic [IW-1:0] cur_ff;
   logic [31:0] idc_ff;

   // scan counter and results
   logic [IW-1:0] cnt_ff;
   logic [IW-1:0] rr_ff;     // round-robin index under test
   logic          free_v_ff, match_v_ff, rdy_v_ff;
   logic [IW-1:0] free_ff, match_ff, rdy_ff;

   assign stat.scan_last = (cnt_ff == LAST);
   assign rsp_data = rsp_ff;

   logic [IW-1:0] rr_next, rr_first;
   always_comb begin
      rr_next = (rr_ff == LAST) ? '0 : rr_ff + 1'b1;
      rr_first = (cur_ff == LAST) ? '0 : cur_ff + 1'b1;
   end

   logic [IW-1:0] cidx;
   assign cidx = cnt_ff;

   // commit values
   logic [IW-1:0] sel_i;
   logic          sel_in;
   logic          rr_hit;
   assign sel_in = ({28'd0, rq_ff.slot_index} < 32'(TABLE_SLOTS));
   assign sel_i = IW'(rq_ff.slot_index);
   // exit never hands control back to the slot that is leaving
   assign rr_hit = (st_ff[rr_ff] == ST_READY)
                   && !(rq_ff.operation == OP_EXIT && rr_ff == cur_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            st_ff[i] <= ST_UNUSED;
            pid_ff[i] <= '0;
            par_ff[i] <= '0;
            tick_ff[i] <= '0;
            exit_ff[i] <= '0;
         end
         cur_v_ff <= 1'b0;
         cur_ff <= '0;
         idc_ff <= 32'd1;
         cnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            rq_ff <= req_data;
            cnt_ff <= '0;
            rr_ff <= rr_first;
            free_v_ff <= 1'b0;
            match_v_ff <= 1'b0;
            rdy_v_ff <= 1'b0;
         end
         if (cmd.step) begin
            cnt_ff <= (cnt_ff == LAST) ? '0 : cnt_ff + 1'b1;
            rr_ff <= rr_next;
            if (!free_v_ff && st_ff[cidx] == ST_UNUSED) begin
               free_v_ff <= 1'b1;
               free_ff <= cidx;
            end
            if (!match_v_ff && st_ff[cidx] != ST_UNUSED && pid_ff[cidx] == rq_ff.target_pid)
            begin
               match_v_ff <= 1'b1;
               match_ff <= cidx;
            end
            if (!rdy_v_ff && rr_hit) begin
               rdy_v_ff <= 1'b1;
               rdy_ff <= rr_ff;
            end
         end
         if (cmd.commit) begin
            rsp_type r;
            logic          cv;
            logic [IW-1:0] cs;
            r = '0;
            cv = cur_v_ff;
            cs = cur_ff;
            unique case (rq_ff.operation)
               OP_CREATE: begin
                  if (!free_v_ff || !rq_ff.entry_ok) r.status = RS_NO_SLOT;
                  else begin
                     pid_ff[free_ff] <= idc_ff;
                     par_ff[free_ff] <= rq_ff.parent_pid;
                     st_ff[free_ff] <= ST_READY;
                     tick_ff[free_ff] <= '0;
                     exit_ff[free_ff] <= '0;
                     idc_ff <= idc_ff + 32'd1;
                     r.assigned_pid = idc_ff;
                  end
               end
               OP_START: begin
                  if (!match_v_ff) r.status = RS_NOT_FOUND;
                  else begin
                     cv = 1'b1;
                     cs = match_ff;
                     st_ff[match_ff] <= ST_RUNNING;
                  end
               end
               OP_TICK: begin
                  if (cur_v_ff && st_ff[cur_ff] == ST_RUNNING)
                     tick_ff[cur_ff] <= tick_ff[cur_ff] + 32'd1;
               end
               OP_YIELD: begin
                  if (!cur_v_ff || !rdy_v_ff) r.status = RS_NO_READY;
                  else begin
                     if (rdy_ff != cur_ff) st_ff[cur_ff] <= ST_READY;
                     st_ff[rdy_ff] <= ST_RUNNING;
                     cs = rdy_ff;
                     r.switched = 1'b1;
                     r.from_slot = 4'(cur_ff);
                     r.to_slot = 4'(rdy_ff);
                  end
               end
               OP_EXIT: begin
                  if (!cur_v_ff) r.status = RS_HALTED;
                  else begin
                     exit_ff[cur_ff] <= rq_ff.exit_code;
                     if (!rdy_v_ff) begin
                        st_ff[cur_ff] <= ST_ZOMBIE;
                        r.status = RS_HALTED;
                     end else begin
                        // the scan skipped the exiting slot, so rdy differs from cur
                        st_ff[cur_ff] <= ST_ZOMBIE;
                        st_ff[rdy_ff] <= ST_RUNNING;
                        tick_ff[rdy_ff] <= tick_ff[rdy_ff] + 32'd1;
                        cs = rdy_ff;
                        r.switched = 1'b1;
                        r.from_slot = 4'(cur_ff);
                        r.to_slot = 4'(rdy_ff);
                     end
                  end
               end
               OP_REAP: begin
                  if (!match_v_ff || st_ff[match_ff] != ST_ZOMBIE) r.status = RS_NOT_FOUND;
                  else begin
                     pid_ff[match_ff] <= '0;
                     par_ff[match_ff] <= '0;
                     st_ff[match_ff] <= ST_UNUSED;
                  end
               end
               OP_INSPECT: begin
                  if (sel_in) begin
                     r.entry_pid = pid_ff[sel_i];
                     r.entry_state = st_ff[sel_i];
                     r.entry_ticks = tick_ff[sel_i];
                     r.entry_exit_status = exit_ff[sel_i];
                  end
               end
               default: ;
            endcase
            cur_v_ff <= cv;
            cur_ff <= cs;
            // current identity after the step
            if (!cv) begin
               r.current_pid = '0;
               r.current_parent = '0;
            end else if (rq_ff.operation == OP_CREATE && r.status == RS_OK
                         && free_ff == cs) begin
               r.current_pid = idc_ff;
               r.current_parent = rq_ff.parent_pid;
            end else if (rq_ff.operation == OP_REAP && r.status == RS_OK
                         && match_ff == cs) begin
               r.current_pid = '0;
               r.current_parent = '0;
            end else begin
               r.current_pid = pid_ff[cs];
               r.current_parent = par_ff[cs];
            end
            rsp_ff <= r;
         end
      end
   end

endmodule

// ===== rtl/core/process_table_round_robin_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// process_table_round_robin_scheduler_unit
// task table with round-robin scheduling, one response per command
// ----------------------------------------------------------------------------
// flow: capture the request, scan every slot in turn, then register the response
// no new command is accepted while the slot-serial scan or commit is under way
// reset: synchronous, clears the whole table, no current entry, next id 1
module process_table_round_robin_scheduler_unit #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  prr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output prr_pkg::rsp_type rsp_data
);
   import prr_pkg::*;

   prr_cmd_type  cmd;
   prr_stat_type stat;

   prr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .stat(stat)
   );

   prr_dpath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dpath (
      .clock(clock), .reset(reset),
      .req_data(req_data), .rsp_data(rsp_data),
      .cmd(cmd), .stat(stat)
   );

endmodule
